>>> design/pidpc_pkg.sv
// Shared types, constants and register codes of the PID position controller.
package pidpc_pkg;

    // Default width of one measured position sample
    localparam int MEAS_WIDTH_DEFAULT = 18;

    // Field widths
    localparam int SETPOINT_W = 18;
    localparam int GAIN_W     = 16;
    localparam int LIMIT_W    = 24;
    localparam int OUT_W      = 16;
    localparam int INTEG_W    = 25;
    localparam int DRIVE_W    = 17;

    // Configuration port widths
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 24;

    // Output scaling: drive is the weighted sum divided by this constant
    localparam int DIVISOR = 1000;

    // Divide by DIVISOR through a reciprocal multiply. Exact for any
    // nonnegative value below 2^SAT_W, which covers every unsaturated sum.
    localparam int          SAT_W       = 26;
    localparam int          RECIP_W     = 27;
    localparam int          RECIP_SHIFT = 36;
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(68719477);

    // Reset values of the configuration registers
    localparam logic [SETPOINT_W-1:0] SETPOINT_RST   = SETPOINT_W'(100000);
    localparam logic [GAIN_W-1:0]     KP_RST         = GAIN_W'(50);
    localparam logic [GAIN_W-1:0]     KI_RST         = GAIN_W'(1);
    localparam logic [GAIN_W-1:0]     KD_RST         = GAIN_W'(2500);
    localparam logic [LIMIT_W-1:0]    LIMIT_RST      = LIMIT_W'(1000000);
    localparam logic [OUT_W-1:0]      OUTPUT_MAX_RST = OUT_W'(10000);
    localparam logic [OUT_W-1:0]      BIAS_RST       = OUT_W'(200);
    localparam logic [SAT_W-1:0]      SAT_LIMIT_RST  =
        SAT_W'((10000 + 1) * DIVISOR);

    // Register indexes on the configuration port
    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_SETPOINT   = 3'd0,
        REG_GAIN_P     = 3'd1,
        REG_GAIN_I     = 3'd2,
        REG_GAIN_D     = 3'd3,
        REG_INT_LIMIT  = 3'd4,
        REG_OUTPUT_MAX = 3'd5,
        REG_OUTPUT_BIAS = 3'd6
    } cfg_idx_t;

    // Configuration bundle seen by the datapath
    typedef struct packed {
        logic [SETPOINT_W-1:0] setpoint;
        logic [GAIN_W-1:0]     gain_p;
        logic [GAIN_W-1:0]     gain_i;
        logic [GAIN_W-1:0]     gain_d;
        logic [LIMIT_W-1:0]    integral_limit;
        logic [OUT_W-1:0]      output_max;
        logic [OUT_W-1:0]      output_bias;
        logic [SAT_W-1:0]      sat_limit;   // (output_max + 1) * DIVISOR
    } cfg_t;

endpackage

>>> design/pidpc_cfg_regs.sv
// Configuration register file of the PID position controller.
module pidpc_cfg_regs (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wen,
    input  logic [pidpc_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [pidpc_pkg::CFG_DATA_W-1:0] cfg_wdata,
    output pidpc_pkg::cfg_t                 cfg
);
    import pidpc_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Decode a write; the saturation threshold tracks output_max
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wen)
        begin
            unique case (cfg_idx_t'(cfg_addr))
                REG_SETPOINT:    cfg_next.setpoint       = cfg_wdata[SETPOINT_W-1:0];
                REG_GAIN_P:      cfg_next.gain_p         = cfg_wdata[GAIN_W-1:0];
                REG_GAIN_I:      cfg_next.gain_i         = cfg_wdata[GAIN_W-1:0];
                REG_GAIN_D:      cfg_next.gain_d         = cfg_wdata[GAIN_W-1:0];
                REG_INT_LIMIT:   cfg_next.integral_limit = cfg_wdata[LIMIT_W-1:0];
                REG_OUTPUT_MAX:  cfg_next.output_max     = cfg_wdata[OUT_W-1:0];
                REG_OUTPUT_BIAS: cfg_next.output_bias    = cfg_wdata[OUT_W-1:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
        cfg_next.sat_limit =
            SAT_W'((32'(cfg_reg.output_max) + 32'd1) * 32'(DIVISOR));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.setpoint       <= SETPOINT_RST;
            cfg_reg.gain_p         <= KP_RST;
            cfg_reg.gain_i         <= KI_RST;
            cfg_reg.gain_d         <= KD_RST;
            cfg_reg.integral_limit <= LIMIT_RST;
            cfg_reg.output_max     <= OUTPUT_MAX_RST;
            cfg_reg.output_bias    <= BIAS_RST;
            cfg_reg.sat_limit      <= SAT_LIMIT_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

>>> design/pidpc_error_stage.sv
// Input register, error and derivative, and the clamped error integral.
module pidpc_error_stage #(
    parameter int MEAS_WIDTH = pidpc_pkg::MEAS_WIDTH_DEFAULT,
    parameter int DW = ((MEAS_WIDTH > pidpc_pkg::SETPOINT_W) ?
                        MEAS_WIDTH : pidpc_pkg::SETPOINT_W) + 1
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  pidpc_pkg::cfg_t               cfg,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [MEAS_WIDTH-1:0]         in_meas,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [DW-1:0]          out_err,
    output logic signed [DW-1:0]          out_deriv,
    output logic signed [pidpc_pkg::INTEG_W-1:0] out_acc
);
    import pidpc_pkg::*;

    localparam int AW = ((DW > INTEG_W) ? DW : INTEG_W) + 1;

    logic                      meas_valid_reg;
    logic [MEAS_WIDTH-1:0]     meas_reg;
    logic                      a_valid_reg;
    logic signed [DW-1:0]      err_reg;
    logic signed [DW-1:0]      deriv_reg;
    logic signed [INTEG_W-1:0] acc_reg;
    logic [MEAS_WIDTH-1:0]     prev_reg;
    logic signed [INTEG_W-1:0] integral_reg;

    logic                      a_ready;
    logic                      a_load;
    logic signed [DW-1:0]      err_next;
    logic signed [DW-1:0]      deriv_next;
    logic signed [AW-1:0]      acc_sum;
    logic signed [AW-1:0]      lim_s;
    logic signed [AW-1:0]      acc_clamped;
    logic signed [INTEG_W-1:0] acc_next;

    // Stage handshake: a stage takes a new word when empty or draining
    assign a_ready  = !a_valid_reg || out_ready;
    assign in_ready = !meas_valid_reg || a_ready;
    assign a_load   = meas_valid_reg && a_ready;

    // Error, derivative and the integral update with its clamp
    always_comb
    begin
        err_next    = $signed(DW'(cfg.setpoint)) - $signed(DW'(meas_reg));
        deriv_next  = $signed(DW'(meas_reg)) - $signed(DW'(prev_reg));
        lim_s       = $signed(AW'(cfg.integral_limit));
        acc_sum     = AW'(integral_reg) + AW'(err_next);
        acc_clamped = acc_sum;
        if (acc_sum > lim_s)
        begin
            acc_clamped = lim_s;
        end
        if (acc_sum < -lim_s)
        begin
            acc_clamped = -lim_s;
        end
        acc_next = $signed(acc_clamped[INTEG_W-1:0]);
    end

    // Control and loop state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            meas_valid_reg <= 1'b0;
            a_valid_reg    <= 1'b0;
            prev_reg       <= '0;
            integral_reg   <= '0;
        end
        else
        begin
            if (in_ready)
            begin
                meas_valid_reg <= in_valid;
            end
            if (a_ready)
            begin
                a_valid_reg <= meas_valid_reg;
            end
            if (a_load)
            begin
                prev_reg     <= meas_reg;
                integral_reg <= acc_next;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            meas_reg <= in_meas;
        end
        if (a_load)
        begin
            err_reg   <= err_next;
            deriv_reg <= deriv_next;
            acc_reg   <= acc_next;
        end
    end

    assign out_valid = a_valid_reg;
    assign out_err   = err_reg;
    assign out_deriv = deriv_reg;
    assign out_acc   = acc_reg;

    // The integral handed on is always within the configured limit
    assert property (@(posedge clk) disable iff (!rst_n)
        a_load |=> ($signed(AW'(acc_reg)) <= lim_s) && ($signed(AW'(acc_reg)) >= -lim_s))
        else $error("integral outside its clamp");

    // The previous measurement follows the word just processed
    assert property (@(posedge clk) disable iff (!rst_n)
        a_load |=> (prev_reg == $past(meas_reg)) && (integral_reg == acc_reg))
        else $error("loop state out of step with the pipeline");

endmodule

>>> design/pidpc_gain_stage.sv
// Gain products and their full-width weighted sum.
module pidpc_gain_stage #(
    parameter int MEAS_WIDTH = pidpc_pkg::MEAS_WIDTH_DEFAULT,
    parameter int DW = ((MEAS_WIDTH > pidpc_pkg::SETPOINT_W) ?
                        MEAS_WIDTH : pidpc_pkg::SETPOINT_W) + 1,
    parameter int PRW = DW + pidpc_pkg::GAIN_W + 1,
    parameter int IPW = pidpc_pkg::INTEG_W + pidpc_pkg::GAIN_W + 1,
    parameter int SW = ((PRW > IPW) ? PRW : IPW) + 2
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  pidpc_pkg::cfg_t               cfg,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [DW-1:0]          in_err,
    input  logic signed [DW-1:0]          in_deriv,
    input  logic signed [pidpc_pkg::INTEG_W-1:0] in_acc,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [SW-1:0]          out_sum
);
    import pidpc_pkg::*;

    logic                  b_valid_reg;
    logic                  c_valid_reg;
    logic signed [PRW-1:0] p_prop_reg;
    logic signed [IPW-1:0] p_integ_reg;
    logic signed [PRW-1:0] p_deriv_reg;
    logic signed [SW-1:0]  sum_reg;

    logic                  b_ready;
    logic                  c_ready;
    logic signed [PRW-1:0] p_prop_next;
    logic signed [IPW-1:0] p_integ_next;
    logic signed [PRW-1:0] p_deriv_next;
    logic signed [SW-1:0]  sum_next;

    assign c_ready  = !c_valid_reg || out_ready;
    assign b_ready  = !b_valid_reg || c_ready;
    assign in_ready = b_ready;

    // Three gain products, each registered before the sum
    always_comb
    begin
        p_prop_next  = $signed(PRW'(cfg.gain_p)) * PRW'(in_err);
        p_integ_next = $signed(IPW'(cfg.gain_i)) * IPW'(in_acc);
        p_deriv_next = $signed(PRW'(cfg.gain_d)) * PRW'(in_deriv);
        sum_next     = SW'(p_prop_reg) + SW'(p_integ_reg) - SW'(p_deriv_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end
        else
        begin
            if (b_ready)
            begin
                b_valid_reg <= in_valid;
            end
            if (c_ready)
            begin
                c_valid_reg <= b_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (b_ready && in_valid)
        begin
            p_prop_reg  <= p_prop_next;
            p_integ_reg <= p_integ_next;
            p_deriv_reg <= p_deriv_next;
        end
        if (c_ready && b_valid_reg)
        begin
            sum_reg <= sum_next;
        end
    end

    assign out_valid = c_valid_reg;
    assign out_sum   = sum_reg;

endmodule

>>> design/pidpc_scale_stage.sv
// Divide by the scale constant, clamp to the output range and add the bias.
module pidpc_scale_stage #(
    parameter int MEAS_WIDTH = pidpc_pkg::MEAS_WIDTH_DEFAULT,
    parameter int DW = ((MEAS_WIDTH > pidpc_pkg::SETPOINT_W) ?
                        MEAS_WIDTH : pidpc_pkg::SETPOINT_W) + 1,
    parameter int PRW = DW + pidpc_pkg::GAIN_W + 1,
    parameter int IPW = pidpc_pkg::INTEG_W + pidpc_pkg::GAIN_W + 1,
    parameter int SW = ((PRW > IPW) ? PRW : IPW) + 2
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  pidpc_pkg::cfg_t                cfg,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic signed [SW-1:0]           in_sum,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [pidpc_pkg::DRIVE_W-1:0]  out_drive
);
    import pidpc_pkg::*;

    localparam int PW = SAT_W + RECIP_W;

    logic                   d_valid_reg;
    logic                   d_zero_reg;
    logic                   d_sat_reg;
    logic [SAT_W-1:0]       d_val_reg;
    logic                   e_valid_reg;
    logic                   e_zero_reg;
    logic                   e_sat_reg;
    logic [OUT_W-1:0]       e_quot_reg;
    logic                   f_valid_reg;
    logic [DRIVE_W-1:0]     drive_reg;

    logic                   d_ready;
    logic                   e_ready;
    logic                   f_ready;
    logic                   d_sat_next;
    logic [PW-1:0]          prod;
    logic [OUT_W-1:0]       sel;
    logic [DRIVE_W-1:0]     drive_next;

    assign f_ready  = !f_valid_reg || out_ready;
    assign e_ready  = !e_valid_reg || f_ready;
    assign d_ready  = !d_valid_reg || e_ready;
    assign in_ready = d_ready;

    // Classify: negative sums give zero, sums at or above the threshold saturate
    assign d_sat_next = in_sum >= $signed(SW'(cfg.sat_limit));

    // Quotient of an unsaturated sum by reciprocal multiply
    assign prod = PW'(d_val_reg) * PW'(RECIP);

    // Final selection and bias
    always_comb
    begin
        if (e_zero_reg)
        begin
            sel = '0;
        end
        else if (e_sat_reg)
        begin
            sel = cfg.output_max;
        end
        else
        begin
            sel = e_quot_reg;
        end
        drive_next = DRIVE_W'(sel) + DRIVE_W'(cfg.output_bias);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d_valid_reg <= 1'b0;
            e_valid_reg <= 1'b0;
            f_valid_reg <= 1'b0;
        end
        else
        begin
            if (d_ready)
            begin
                d_valid_reg <= in_valid;
            end
            if (e_ready)
            begin
                e_valid_reg <= d_valid_reg;
            end
            if (f_ready)
            begin
                f_valid_reg <= e_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (d_ready && in_valid)
        begin
            d_zero_reg <= in_sum[SW-1];
            d_sat_reg  <= d_sat_next;
            d_val_reg  <= in_sum[SAT_W-1:0];
        end
        if (e_ready && d_valid_reg)
        begin
            e_zero_reg <= d_zero_reg;
            e_sat_reg  <= d_sat_reg;
            e_quot_reg <= prod[RECIP_SHIFT +: OUT_W];
        end
        if (f_ready && e_valid_reg)
        begin
            drive_reg <= drive_next;
        end
    end

    assign out_valid = f_valid_reg;
    assign out_drive = drive_reg;

    // An unsaturated quotient never exceeds the output maximum
    assert property (@(posedge clk) disable iff (!rst_n)
        (e_valid_reg && !e_zero_reg && !e_sat_reg) |-> (e_quot_reg <= cfg.output_max))
        else $error("scaled quotient above output maximum");

    // A delivered word stays within the clamped range plus bias
    assert property (@(posedge clk) disable iff (!rst_n)
        f_valid_reg |->
            (drive_reg <= DRIVE_W'(cfg.output_max) + DRIVE_W'(cfg.output_bias))
            && (drive_reg >= DRIVE_W'(cfg.output_bias)))
        else $error("drive outside its range");

endmodule

>>> design/pid_position_controller.sv
// Top level of the PID position controller.
//
// One measured position word enters on the s_axis channel and one drive
// word leaves on the m_axis channel for each of them, in order. Error is
// setpoint minus measurement, derivative is measurement minus the previous
// measurement, and the error integral is clamped to +/- integral_limit.
// The weighted sum is divided by 1000 (toward zero), clamped to
// 0..output_max and offset by output_bias.
// An accepted input word passes the input, error, product, sum, classify,
// quotient and drive registers. Throughput is one word per cycle when m_axis
// does not stall; the only loop, the integral add and clamp, is in the error stage.
// Every stage has its own valid bit and loads when empty or draining, so
// gaps in the pipeline are filled while a finished word waits on m_axis.
// When the receiver stalls, the pipeline fills up and s_axis_tready drops
// only once all stages hold a word.
// Reset clears the pipeline, the previous measurement and the integral,
// and loads the default register values. Registers must be written through
// cfg_wen/cfg_addr/cfg_wdata while the block is idle; the block does not enforce it.
module pid_position_controller #(
    parameter int MEAS_WIDTH = pidpc_pkg::MEAS_WIDTH_DEFAULT,
    parameter int IN_BYTES_W = ((MEAS_WIDTH + 7) / 8) * 8
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_wen,
    input  logic [pidpc_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [pidpc_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [IN_BYTES_W-1:0]            s_axis_tdata,  // measured_position
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [23:0]                      m_axis_tdata   // drive, zero pad
);
    import pidpc_pkg::*;

    localparam int DW  = ((MEAS_WIDTH > SETPOINT_W) ? MEAS_WIDTH : SETPOINT_W) + 1;
    localparam int PRW = DW + GAIN_W + 1;
    localparam int IPW = INTEG_W + GAIN_W + 1;
    localparam int SW  = ((PRW > IPW) ? PRW : IPW) + 2;

    cfg_t                      cfg;
    logic                      err_valid;
    logic                      err_ready;
    logic signed [DW-1:0]      err;
    logic signed [DW-1:0]      deriv;
    logic signed [INTEG_W-1:0] acc;
    logic                      sum_valid;
    logic                      sum_ready;
    logic signed [SW-1:0]      sum;
    logic [DRIVE_W-1:0]        drive;

    pidpc_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wen   (cfg_wen),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    pidpc_error_stage #(
        .MEAS_WIDTH (MEAS_WIDTH),
        .DW         (DW)
    ) u_error (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_meas   (s_axis_tdata[MEAS_WIDTH-1:0]),
        .out_valid (err_valid),
        .out_ready (err_ready),
        .out_err   (err),
        .out_deriv (deriv),
        .out_acc   (acc)
    );

    pidpc_gain_stage #(
        .MEAS_WIDTH (MEAS_WIDTH),
        .DW         (DW),
        .PRW        (PRW),
        .IPW        (IPW),
        .SW         (SW)
    ) u_gain (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (err_valid),
        .in_ready  (err_ready),
        .in_err    (err),
        .in_deriv  (deriv),
        .in_acc    (acc),
        .out_valid (sum_valid),
        .out_ready (sum_ready),
        .out_sum   (sum)
    );

    pidpc_scale_stage #(
        .MEAS_WIDTH (MEAS_WIDTH),
        .DW         (DW),
        .PRW        (PRW),
        .IPW        (IPW),
        .SW         (SW)
    ) u_scale (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (sum_valid),
        .in_ready  (sum_ready),
        .in_sum    (sum),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_drive (drive)
    );

    assign m_axis_tdata = 24'(drive);

endmodule
